@@ rtl/gpps_pkg.sv @@
// ----------------------------------------------------------------------------
// gpps_pkg
// Shared types and constants of the grid point program store: op and status
// codes, controller states, and the command and status bundles.
// ----------------------------------------------------------------------------
package gpps_pkg;

  // fixed field widths
  localparam int COORD_W    = 8;
  localparam int DUR_W      = 16;
  localparam int IDX_W      = 8;
  localparam int CFG_ADDR_W = 1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_X_MIN = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_Y_MAX = 1'd1;

  // configuration reset values
  localparam logic [COORD_W-1:0] X_MIN_RST = 8'hFC;
  localparam logic [COORD_W-1:0] Y_MAX_RST = 8'h03;

  // input op codes
  typedef enum logic [1:0] {
    OP_ADD_POINT = 2'd0,
    OP_END_LINE  = 2'd1,
    OP_NEXT_LINE = 2'd2,
    OP_CLEAR     = 2'd3
  } gpps_op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_OOB       = 2'd2,
    ST_EMPTY     = 2'd3
  } gpps_status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_PLAY
  } gpps_state_t;

  // controller to datapath
  typedef struct packed {
    logic add_point;
    logic end_line;
    logic next_line;
    logic clear;
    logic load_line;
    logic play_step;
  } gpps_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic prog_empty;
    logic line_empty;
    logic row_empty;
    logic last_point;
  } gpps_stat_t;

  // one result item
  typedef struct packed {
    gpps_status_t       status;
    logic               point_valid;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [DUR_W-1:0]   line_duration;
    logic [IDX_W-1:0]   line_index;
    logic               last;
  } gpps_res_t;

endpackage

@@ rtl/gpps_ctrl.sv @@
// ----------------------------------------------------------------------------
// gpps_ctrl
// Sequencer: takes input items, fetches a line for playback and steps the
// datapath through its points one result at a time.
// ----------------------------------------------------------------------------
module gpps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         in_op,
  input  gpps_pkg::gpps_stat_t stat,
  output gpps_pkg::gpps_cmd_t  cmd
);
  import gpps_pkg::*;

  gpps_state_t state_r;
  gpps_state_t state_nxt;
  gpps_op_t    op;

  assign op = gpps_op_t'(in_op);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = stat.out_free;
        if (in_tvalid && stat.out_free) begin
          unique case (op)
            OP_ADD_POINT: cmd.add_point = 1'b1;
            OP_END_LINE:  cmd.end_line  = 1'b1;
            OP_NEXT_LINE: begin
              cmd.next_line = 1'b1;
              if (!stat.prog_empty) begin
                state_nxt = S_LOAD;
              end
            end
            OP_CLEAR:     cmd.clear     = 1'b1;
            default:      cmd           = '0;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load_line = 1'b1;
        state_nxt     = S_PLAY;
      end
      S_PLAY: begin
        if (stat.out_free) begin
          cmd.play_step = 1'b1;
          if (stat.line_empty || (!stat.row_empty && stat.last_point)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/gpps_dp.sv @@
// ----------------------------------------------------------------------------
// gpps_dp
// Datapath: coordinate registers, staging bitmask, line table memory,
// line count and play position, playback line buffer and result register.
// ----------------------------------------------------------------------------
module gpps_dp #(
  parameter int AXIS  = 8,
  parameter int LINES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gpps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gpps_pkg::COORD_W-1:0]         cfg_wdata,
  input  logic [gpps_pkg::COORD_W-1:0]         in_x,
  input  logic [gpps_pkg::COORD_W-1:0]         in_y,
  input  logic [gpps_pkg::DUR_W-1:0]           in_dur,
  input  gpps_pkg::gpps_cmd_t                  cmd,
  output gpps_pkg::gpps_stat_t                 stat,
  input  logic                                 out_tready,
  output logic                                 out_valid,
  output gpps_pkg::gpps_res_t                  out_res
);
  import gpps_pkg::*;

  localparam int COL_W  = $clog2(AXIS);
  localparam int LINE_W = AXIS * AXIS;
  localparam int MEM_W  = LINE_W + DUR_W;
  localparam int CNT_W  = $clog2(LINES + 1);
  localparam int POS_W  = (LINES > 1) ? $clog2(LINES) : 1;

  // configuration and control state
  logic [COORD_W-1:0]            xmin_r;
  logic [COORD_W-1:0]            ymax_r;
  logic [AXIS-1:0][AXIS-1:0]     stage_r;
  logic [AXIS-1:0][AXIS-1:0]     stage_nxt;
  logic [CNT_W-1:0]              cnt_r;
  logic                          before_r;
  logic [POS_W-1:0]              pos_r;
  logic [POS_W-1:0]              pos_nxt;
  logic [CNT_W-1:0]              pos_inc;
  logic                          full;
  logic                          prog_empty;

  // line table
  logic [MEM_W-1:0]              mem [LINES];
  logic [MEM_W-1:0]              rd_r;
  logic                          wr_en;

  // point decode
  logic [COORD_W:0]              col_s;
  logic [COORD_W:0]              row_s;
  logic                          pt_ok;

  // playback buffer
  logic [AXIS-1:0][AXIS-1:0]     line_r;
  logic [AXIS-1:0][AXIS-1:0]     line_rem;
  logic [DUR_W-1:0]              dur_r;
  logic [COL_W-1:0]              row_r;
  logic                          empty_r;
  logic [AXIS-1:0]               cur_row;
  logic [COL_W-1:0]              bit_idx;
  logic                          row_empty;
  logic                          last_point;
  logic                          emit;

  // result register
  logic                          out_valid_r;
  logic                          out_valid_nxt;
  gpps_res_t                     res_r;
  gpps_res_t                     res_nxt;

  // point to column and row, with bounds check
  always_comb begin
    col_s = {in_x[COORD_W-1], in_x} - {xmin_r[COORD_W-1], xmin_r};
    row_s = {ymax_r[COORD_W-1], ymax_r} - {in_y[COORD_W-1], in_y};
    pt_ok = !col_s[COORD_W] && (col_s < (COORD_W + 1)'(AXIS)) &&
            !row_s[COORD_W] && (row_s < (COORD_W + 1)'(AXIS));
  end

  // staging mask update
  always_comb begin
    stage_nxt = stage_r;
    if (cmd.add_point && pt_ok) begin
      stage_nxt[row_s[COL_W-1:0]][col_s[COL_W-1:0]] = 1'b1;
    end
    if (cmd.end_line) begin
      stage_nxt = '0;
    end
  end

  // table status and next play position
  assign full       = (cnt_r == CNT_W'(LINES));
  assign prog_empty = (cnt_r == '0);
  assign wr_en      = cmd.end_line && !full;
  assign pos_inc    = CNT_W'(pos_r) + CNT_W'(1);

  always_comb begin
    if (before_r || (pos_inc >= cnt_r)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_inc[POS_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r      <= X_MIN_RST;
      ymax_r      <= Y_MAX_RST;
      stage_r     <= '0;
      cnt_r       <= '0;
      before_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_X_MIN: xmin_r <= cfg_wdata;
          CFG_Y_MAX: ymax_r <= cfg_wdata;
          default:   xmin_r <= xmin_r;
        endcase
      end
      stage_r <= stage_nxt;
      if (wr_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.clear) begin
        cnt_r    <= '0;
        before_r <= 1'b1;
      end
      if (cmd.next_line && !prog_empty) begin
        before_r <= 1'b0;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // play position
  always_ff @(posedge clk) begin
    if (cmd.next_line && !prog_empty) begin
      pos_r <= pos_nxt;
    end
  end

  // line table memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[POS_W-1:0]] <= {in_dur, stage_r};
    end
    if (cmd.next_line) begin
      rd_r <= mem[pos_nxt];
    end
  end

  // lowest set bit of the current row
  always_comb begin
    cur_row   = line_r[row_r];
    row_empty = (cur_row == '0);
    bit_idx   = '0;
    for (int i = AXIS - 1; i >= 0; i--) begin
      if (cur_row[i]) begin
        bit_idx = COL_W'(i);
      end
    end
    line_rem                 = line_r;
    line_rem[row_r][bit_idx] = 1'b0;
    last_point               = (line_rem == '0);
  end

  assign emit = cmd.play_step && (empty_r || !row_empty);

  // playback buffer
  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      line_r  <= rd_r[LINE_W-1:0];
      dur_r   <= rd_r[MEM_W-1:LINE_W];
      row_r   <= '0;
      empty_r <= (rd_r[LINE_W-1:0] == '0);
    end else if (cmd.play_step && !empty_r) begin
      if (row_empty) begin
        row_r <= row_r + COL_W'(1);
      end else begin
        line_r <= line_rem;
      end
    end
  end

  // result selection
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    res_nxt       = res_r;
    if (cmd.add_point || cmd.end_line || cmd.clear ||
        (cmd.next_line && prog_empty) || emit) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      res_nxt.last  = 1'b1;
      res_nxt.status = ST_OK;
      if (cmd.add_point && !pt_ok) begin
        res_nxt.status = ST_OOB;
      end
      if (cmd.end_line && full) begin
        res_nxt.status = ST_FULL;
      end
      if (cmd.next_line) begin
        res_nxt.status = ST_EMPTY;
      end
      if (emit) begin
        res_nxt.line_duration = dur_r;
        res_nxt.line_index    = IDX_W'(pos_r);
        if (!empty_r) begin
          res_nxt.point_valid = 1'b1;
          res_nxt.point_x     = xmin_r + COORD_W'(bit_idx);
          res_nxt.point_y     = ymax_r - COORD_W'(row_r);
          res_nxt.last        = last_point;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // status to the controller
  assign stat.out_free   = !out_valid_r || out_tready;
  assign stat.prog_empty = prog_empty;
  assign stat.line_empty = empty_r;
  assign stat.row_empty  = row_empty;
  assign stat.last_point = last_point;

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

@@ rtl/grid_point_program_store_unit.sv @@
// ----------------------------------------------------------------------------
// grid_point_program_store_unit
// Cyclic program of grid lines: stages points into a bitmask, commits lines
// with a duration to a table and plays them back point by point.
// ----------------------------------------------------------------------------
// add_point, end_line and clear each give one result. next_line gives one
// empty-program result when the table is empty; else it fetches the line
// through the registered table read, loads the line buffer and then gives
// one point per cycle while the output register is free, stepping over each
// empty row on the way. A new item is taken once the last result of the
// previous one has entered the output register; while that register holds a
// result that downstream has not taken, the input is held off. The table
// memory is not cleared after reset: only lines committed since the last
// reset or clear are ever played.
module grid_point_program_store_unit #(
  parameter int AXIS  = 8,
  parameter int LINES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [gpps_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gpps_pkg::COORD_W-1:0]    cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x[7:0], y[15:8], duration[31:16]
  input  logic [1:0]  in_tuser,   // op[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[1:0], point_x[9:2], point_y[17:10],
                                  // line_duration[33:18], line_index[41:34], zero
  output logic        out_tuser,  // point_valid
  output logic        out_tlast
);
  import gpps_pkg::*;

  gpps_cmd_t  cmd;
  gpps_stat_t stat;
  gpps_res_t  res;

  // sequencer
  gpps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and playback
  gpps_dp #(
    .AXIS  (AXIS),
    .LINES (LINES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_x       (in_tdata[7:0]),
    .in_y       (in_tdata[15:8]),
    .in_dur     (in_tdata[31:16]),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (res)
  );

  // result packing
  assign out_tdata = {6'b0, res.line_index, res.line_duration, res.point_y,
                      res.point_x, res.status};
  assign out_tuser = res.point_valid;
  assign out_tlast = res.last;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the grid point program store. Points are staged,
// committed as lines and played back over the input and result streams.
// Every transfer in is run through a local predictor, and every transfer out
// is compared field by field with the oldest prediction. Grid origin
// settings change between phases, and one phase fills the line table.
// ----------------------------------------------------------------------------
module testbench;
  import gpps_pkg::*;

  localparam int AXIS           = 8;
  localparam int LINES          = 256;
  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  // directed stimulus row: typed rows carry a known single result
  typedef struct {
    gpps_op_t          op;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic [15:0]       dur;
    bit                typed;
    gpps_status_t      status;
  } step_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_X_MIN;
  logic [COORD_W-1:0]    cfg_wdata = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;  // x[7:0], y[15:8], duration[31:16]
  logic [1:0]  in_tuser   = '0;  // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // status[1:0], point_x[9:2], point_y[17:10],
                                 // line_duration[33:18], line_index[41:34], zero
  logic        out_tuser;        // point_valid
  logic        out_tlast;

  // predicted grid state
  logic signed [7:0] grid_x_min;
  logic signed [7:0] grid_y_max;
  logic [7:0]        table_rows [LINES][AXIS];
  logic [15:0]       table_dur [LINES];
  logic [7:0]        stage_rows [AXIS];
  int                lines_held;
  int                play_line;

  gpps_res_t pending_results[$];

  int errors        = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int points_played = 0;
  int full_seen     = 0;
  int oob_seen      = 0;
  int empty_seen    = 0;
  int grid_settings = 0;
  int burst_left    = 0;
  int stall_cycles  = 0;
  int ready_mode    = 0;
  int ready_hold    = 0;
  int unsigned cycle_cnt = 0;

  step_row_t directed_steps [20] = '{
    '{OP_NEXT_LINE,    0,    0, 16'h0000, 1'b1, ST_EMPTY},
    '{OP_ADD_POINT,   -4,    3, 16'h0000, 1'b1, ST_OK},
    '{OP_ADD_POINT,    3,   -4, 16'hFFFF, 1'b1, ST_OK},
    '{OP_ADD_POINT,    4,    0, 16'h0000, 1'b1, ST_OOB},
    '{OP_ADD_POINT,   -5,    0, 16'h0000, 1'b1, ST_OOB},
    '{OP_ADD_POINT,    0,    4, 16'h0000, 1'b1, ST_OOB},
    '{OP_ADD_POINT,    0,   -5, 16'h0000, 1'b1, ST_OOB},
    '{OP_ADD_POINT,  127, -128, 16'h0000, 1'b1, ST_OOB},
    '{OP_ADD_POINT, -128,  127, 16'h0000, 1'b1, ST_OOB},
    '{OP_ADD_POINT,    0,    0, 16'h0000, 1'b0, ST_OK},
    '{OP_END_LINE,     0,    0, 16'hFFFF, 1'b1, ST_OK},
    '{OP_END_LINE,   127, -128, 16'h0000, 1'b1, ST_OK},
    '{OP_NEXT_LINE,    0,    0, 16'h0000, 1'b0, ST_OK},
    '{OP_NEXT_LINE,    0,    0, 16'h0000, 1'b0, ST_OK},
    '{OP_NEXT_LINE,    0,    0, 16'h0000, 1'b0, ST_OK},
    '{OP_CLEAR,       -1,   -1, 16'hFFFF, 1'b1, ST_OK},
    '{OP_NEXT_LINE,    0,    0, 16'h0000, 1'b1, ST_EMPTY},
    '{OP_ADD_POINT,   -1,    1, 16'h0000, 1'b0, ST_OK},
    '{OP_END_LINE,     0,    0, 16'h1234, 1'b0, ST_OK},
    '{OP_NEXT_LINE,    0,    0, 16'h0000, 1'b0, ST_OK}
  };

  grid_point_program_store_unit #(
    .AXIS  (AXIS),
    .LINES (LINES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor: state after reset
  task automatic grid_reset();
    grid_x_min = X_MIN_RST;
    grid_y_max = Y_MAX_RST;
    foreach (stage_rows[r]) stage_rows[r] = '0;
    lines_held = 0;
    play_line  = -1;
  endtask

  // predictor: results of one accepted item, with the state update
  function automatic void grid_step(input gpps_op_t op, input logic signed [7:0] x,
                                    input logic signed [7:0] y, input logic [15:0] dur,
                                    ref gpps_res_t res_q[$]);
    int        col;
    int        row;
    gpps_res_t r;
    res_q.delete();
    r      = '0;
    r.last = 1'b1;
    case (op)
      OP_ADD_POINT: begin
        col = int'(x) - int'(grid_x_min);
        row = int'(grid_y_max) - int'(y);
        if (col < 0 || col >= AXIS || row < 0 || row >= AXIS) begin
          r.status = ST_OOB;
        end else begin
          stage_rows[row][col] = 1'b1;
        end
        res_q.push_back(r);
      end
      OP_END_LINE: begin
        if (lines_held == LINES) begin
          r.status = ST_FULL;
        end else begin
          foreach (stage_rows[i]) table_rows[lines_held][i] = stage_rows[i];
          table_dur[lines_held] = dur;
          lines_held++;
        end
        foreach (stage_rows[i]) stage_rows[i] = '0;
        res_q.push_back(r);
      end
      OP_NEXT_LINE: begin
        if (lines_held == 0) begin
          r.status = ST_EMPTY;
          res_q.push_back(r);
        end else begin
          play_line++;
          if (play_line < 0 || play_line >= lines_held) play_line = 0;
          // points in row order, then bit order within a row
          for (row = 0; row < AXIS; row++) begin
            for (col = 0; col < AXIS; col++) begin
              if (table_rows[play_line][row][col]) begin
                r.point_valid   = 1'b1;
                r.point_x       = 8'(int'(grid_x_min) + col);
                r.point_y       = 8'(int'(grid_y_max) - row);
                r.line_duration = table_dur[play_line];
                r.line_index    = 8'(play_line);
                r.last          = 1'b0;
                res_q.push_back(r);
              end
            end
          end
          if (res_q.size() == 0) begin
            // empty line still reports its duration and position
            r.line_duration = table_dur[play_line];
            r.line_index    = 8'(play_line);
            res_q.push_back(r);
          end else begin
            r      = res_q.pop_back();
            r.last = 1'b1;
            res_q.push_back(r);
          end
        end
      end
      default: begin
        lines_held = 0;
        play_line  = -1;
        res_q.push_back(r);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
  endtask

  // sender: bursts of transfers with random gaps, called just after the clock rises
  task automatic send_item(input gpps_op_t op, input logic signed [7:0] x,
                           input logic signed [7:0] y, input logic [15:0] dur,
                           input bit typed, input gpps_status_t typed_status);
    gpps_res_t res_q[$];
    gpps_res_t r;
    int        gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(1, 10);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {dur, y, x};
    in_tuser  <= op;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    items_sent++;
    grid_step(op, x, y, dur, res_q);
    if (typed) begin
      r        = '0;
      r.status = typed_status;
      r.last   = 1'b1;
      res_q    = '{r};
    end
    foreach (res_q[i]) begin
      case (res_q[i].status)
        ST_FULL:  full_seen++;
        ST_OOB:   oob_seen++;
        ST_EMPTY: empty_seen++;
        default:  if (res_q[i].point_valid) points_played++;
      endcase
      pending_results.push_back(res_q[i]);
    end
  endtask

  // sender holds off until every predicted result has come back
  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // both origin registers, written while the block is idle
  task automatic set_grid(input logic signed [7:0] x_min, input logic signed [7:0] y_max);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_X_MIN;
    cfg_wdata <= x_min;
    @(posedge clk);
    cfg_addr  <= CFG_Y_MAX;
    cfg_wdata <= y_max;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_x_min = x_min;
    grid_y_max = y_max;
    grid_settings++;
  endtask

  // one in-bounds point for the current origin
  task automatic add_grid_point();
    int max_col;
    int max_row;
    int col;
    int row;
    max_col = (127 - int'(grid_x_min) < AXIS - 1) ? 127 - int'(grid_x_min) : AXIS - 1;
    max_row = (int'(grid_y_max) + 128 < AXIS - 1) ? int'(grid_y_max) + 128 : AXIS - 1;
    col = $urandom_range(0, max_col);
    row = $urandom_range(0, max_row);
    send_item(OP_ADD_POINT, 8'(int'(grid_x_min) + col), 8'(int'(grid_y_max) - row),
              16'($urandom), 1'b0, ST_OK);
  endtask

  // well-formed line: a few points, some noise, then a commit
  task automatic build_line();
    logic [15:0] dur;
    repeat ($urandom_range(0, 7)) begin
      if ($urandom_range(0, 7) == 0)
        send_item(OP_ADD_POINT, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0, ST_OK);
      else
        add_grid_point();
    end
    case ($urandom_range(0, 5))
      0:       dur = 16'h0000;
      1:       dur = 16'hFFFF;
      default: dur = 16'($urandom);
    endcase
    send_item(OP_END_LINE, 8'($urandom), 8'($urandom), dur, 1'b0, ST_OK);
  endtask

  // commit lines until the table is full and then some
  task automatic fill_table();
    send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0, ST_OK);
    repeat (LINES + 3) begin
      if ($urandom_range(0, 15) == 0) add_grid_point();
      send_item(OP_END_LINE, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0, ST_OK);
    end
    repeat (4) send_item(OP_NEXT_LINE, 8'($urandom), 8'($urandom), 16'($urandom),
                         1'b0, ST_OK);
  endtask

  // receiver: ready pattern switches mode every so often
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_hold <= $urandom_range(16, 160);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (cycle_cnt[1:0] == 2'd0);
      default: out_tready <= (cycle_cnt[2:0] != 3'd0);
    endcase
    cycle_cnt <= cycle_cnt + 1;
  end

  // result checker
  always @(posedge clk) begin
    gpps_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                  results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("status",        16'(out_tdata[1:0]),   16'(want.status));
        check_field("point_valid",   16'(out_tuser),        16'(want.point_valid));
        check_field("point_x",       16'(out_tdata[9:2]),   16'(want.point_x));
        check_field("point_y",       16'(out_tdata[17:10]), 16'(want.point_y));
        check_field("line_duration", out_tdata[33:18],      want.line_duration);
        check_field("line_index",    16'(out_tdata[41:34]), 16'(want.line_index));
        check_field("last",          16'(out_tlast),        16'(want.last));
      end
      results_seen++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
               $realtime, WATCHDOG_LIMIT, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic signed [7:0] x_min_list [6];
    logic signed [7:0] y_max_list [6];
    int                phase;
    x_min_list = '{127, -128, 127, -128, 120, -4};
    y_max_list = '{-128, -128, 127, 127, -121, 3};
    grid_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every op, empty program, empty line, wrap of playback
    foreach (directed_steps[i])
      send_item(directed_steps[i].op, directed_steps[i].x, directed_steps[i].y,
                directed_steps[i].dur, directed_steps[i].typed, directed_steps[i].status);

    // random phases, each under its own origin setting
    phase = 0;
    while (items_sent < RANDOM_ITEMS + $size(directed_steps)) begin
      hold_until_drained();
      if (phase < 6)
        set_grid(x_min_list[phase], y_max_list[phase]);
      else
        set_grid(8'($urandom), 8'($urandom));
      if (phase == 2) fill_table();
      repeat ($urandom_range(3, 8)) begin
        case ($urandom_range(0, 11))
          0, 1, 2, 3, 4, 5:
            build_line();
          6, 7, 8:
            repeat ($urandom_range(1, 4))
              send_item(OP_NEXT_LINE, 8'($urandom), 8'($urandom), 16'($urandom),
                        1'b0, ST_OK);
          9, 10:
            send_item(gpps_op_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                      16'($urandom), 1'b0, ST_OK);
          default:
            send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0, ST_OK);
        endcase
      end
      phase++;
    end

    hold_until_drained();
    repeat (40) @(posedge clk);
    $display("covered %0d items under %0d origin settings, %0d results checked",
             items_sent, grid_settings, results_seen);
    $display("played %0d points; table full %0d, out of bounds %0d, empty program %0d",
             points_played, full_seen, oob_seen, empty_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
